### sv/ffha_pkg.sv
package ffha_pkg;

  localparam int DEF_ARENA_BYTES  = 16777216;
  localparam int DEF_HEADER_BYTES = 24;
  localparam int DEF_MAX_BLOCKS   = 64;

  localparam int SIZE_W = 25;
  localparam int ADDR_W = 24;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] alloc_address;
    logic              success;
  } out_item_t;

  // one block table entry
  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_CHK,
    S_SU_RD,
    S_SU_WR,
    S_INS_WR,
    S_TAKE_WR,
    S_NX_RD,
    S_NX_CHK,
    S_SD_RD,
    S_SD_WR,
    S_MRG_WR,
    S_DONE
  } state_t;

endpackage

### sv/ffha_ram.sv
module ffha_ram
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
  )
  (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/first_fit_heap_allocator_unit.sv
// Channel  Dir  Ports                            Payload
// in       in   in_valid, in_stall, in_data      cmd, request_size, release_address
// out      out  out_valid, out_stall, out_data   alloc_address, success
//
// One request at a time. A table walk reads each visited entry from the block table
// RAM, then checks it; a split moves entries up and a merge moves entries down,
// each move a read then a write. The table RAM has one registered read port.
// After reset the init state writes the initial free block; in_stall is high then.
// in_stall stays high from acceptance until the result transfer completes.
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
  #(
    parameter int ARENA_BYTES  = DEF_ARENA_BYTES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS
  )
  (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
  );

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [26:0]       HDR27    = 27'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] INIT_SZ  = SIZE_W'(ARENA_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0]     MAX_CNT  = CW'(MAX_BLOCKS);

  state_t state_r, state_nxt;

  logic              cmd_r, cmd_nxt;
  logic [25:0]       need_r, need_nxt;          // rounded request
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;            // current table entry
  logic [CW-1:0]     k_r, k_nxt;                // shift pointer
  logic [CW-1:0]     count_r, count_nxt;        // live entries
  logic [25:0]       start_r, start_nxt;        // header offset of idx
  logic [SIZE_W-1:0] cur_sz_r, cur_sz_nxt;
  logic [SIZE_W-1:0] rest_r, rest_nxt;
  logic [SIZE_W-1:0] prev_sz_r, prev_sz_nxt;
  logic              prev_free_r, prev_free_nxt;
  logic              sd_last_r, sd_last_nxt;    // shift-down ends the request
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  logic [CW-1:0] idx_p1, k_m1;
  logic [26:0]   start_hdr;
  logic          alloc_hit, rel_hit, do_split, pred_merge;

  ffha_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign idx_p1     = idx_r + CW'(1);
  assign k_m1       = k_r - CW'(1);
  assign start_hdr  = {1'b0, start_r} + HDR27;
  assign alloc_hit  = (cmd_r == CMD_ALLOC) && rdata.free &&
                      ({1'b0, rdata.size} >= need_r);
  assign rel_hit    = (cmd_r == CMD_RELEASE) && (start_hdr == 27'(addr_r));
  assign do_split   = ({2'b0, rdata.size} > ({1'b0, need_r} + HDR27 + 27'd8)) &&
                      (count_r < MAX_CNT);
  assign pred_merge = (idx_r != '0) && prev_free_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:    state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd == CMD_RELEASE && in_data.release_address == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD:      state_nxt = (idx_r >= count_r) ? S_DONE : S_CHK;
      S_CHK: begin
        priority if (alloc_hit) begin
          state_nxt = do_split ? S_SU_RD : S_TAKE_WR;
        end else if (rel_hit) begin
          state_nxt = S_NX_RD;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_SU_RD:   state_nxt = (k_r > idx_p1) ? S_SU_WR : S_INS_WR;
      S_SU_WR:   state_nxt = S_SU_RD;
      S_INS_WR:  state_nxt = S_TAKE_WR;
      S_TAKE_WR: state_nxt = S_DONE;
      S_NX_RD:   state_nxt = (idx_p1 < count_r) ? S_NX_CHK : S_MRG_WR;
      S_NX_CHK:  state_nxt = rdata.free ? S_SD_RD : S_MRG_WR;
      S_SD_RD: begin
        if (k_r < count_r) begin
          state_nxt = S_SD_WR;
        end else begin
          state_nxt = sd_last_r ? S_DONE : S_MRG_WR;
        end
      end
      S_SD_WR:   state_nxt = S_SD_RD;
      S_MRG_WR:  state_nxt = pred_merge ? S_SD_RD : S_DONE;
      S_DONE:    state_nxt = out_stall ? S_DONE : S_IDLE;
      default:   state_nxt = S_INIT;
    endcase
  end

  // datapath and table access
  always_comb begin
    cmd_nxt       = cmd_r;
    need_nxt      = need_r;
    addr_nxt      = addr_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    count_nxt     = count_r;
    start_nxt     = start_r;
    cur_sz_nxt    = cur_sz_r;
    rest_nxt      = rest_r;
    prev_sz_nxt   = prev_sz_r;
    prev_free_nxt = prev_free_r;
    sd_last_nxt   = sd_last_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;
    unique case (state_r)
      S_INIT: begin
        we        = 1'b1;
        wdata     = '{free: 1'b1, size: INIT_SZ};
        count_nxt = CW'(1);
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt       = in_data.cmd;
          need_nxt      = ({1'b0, in_data.request_size} + 26'd7) & ~26'd7;
          addr_nxt      = in_data.release_address;
          idx_nxt       = '0;
          start_nxt     = '0;
          prev_free_nxt = 1'b0;
          // null release: nothing to do
          if (in_data.cmd == CMD_RELEASE && in_data.release_address == '0) begin
            out_nxt       = '{alloc_address: '0, success: 1'b1};
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_RD: begin
        raddr = idx_r[AW-1:0];
        if (idx_r >= count_r) begin
          out_nxt       = '{alloc_address: '0, success: 1'b0};
          out_valid_nxt = 1'b1;
        end
      end
      S_CHK: begin
        priority if (alloc_hit) begin
          out_nxt = '{alloc_address: start_hdr[ADDR_W-1:0], success: 1'b1};
          if (do_split) begin
            cur_sz_nxt = need_r[SIZE_W-1:0];
            rest_nxt   = SIZE_W'({2'b0, rdata.size} - {1'b0, need_r} - HDR27);
            k_nxt      = count_r;
          end else begin
            cur_sz_nxt = rdata.size;
          end
        end else if (rel_hit) begin
          cur_sz_nxt = rdata.size;
        end else begin
          start_nxt     = 26'(start_hdr + {2'b0, rdata.size});
          idx_nxt       = idx_p1;
          prev_sz_nxt   = rdata.size;
          prev_free_nxt = rdata.free;
        end
      end
      S_SU_RD: begin
        raddr = k_m1[AW-1:0];
      end
      S_SU_WR: begin
        we    = 1'b1;
        waddr = k_r[AW-1:0];
        wdata = rdata;
        k_nxt = k_m1;
      end
      S_INS_WR: begin
        we        = 1'b1;
        waddr     = idx_p1[AW-1:0];
        wdata     = '{free: 1'b1, size: rest_r};
        count_nxt = count_r + CW'(1);
      end
      S_TAKE_WR: begin
        we            = 1'b1;
        waddr         = idx_r[AW-1:0];
        wdata         = '{free: 1'b0, size: cur_sz_r};
        out_valid_nxt = 1'b1;
      end
      S_NX_RD: begin
        raddr = idx_p1[AW-1:0];
      end
      S_NX_CHK: begin
        if (rdata.free) begin
          cur_sz_nxt  = SIZE_W'({2'b0, cur_sz_r} + {2'b0, rdata.size} + HDR27);
          k_nxt       = idx_r + CW'(2);
          sd_last_nxt = 1'b0;
        end
      end
      S_SD_RD: begin
        raddr = k_r[AW-1:0];
        if (k_r >= count_r) begin
          count_nxt = count_r - CW'(1);
          if (sd_last_r) begin
            out_nxt       = '{alloc_address: '0, success: 1'b1};
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_SD_WR: begin
        we    = 1'b1;
        waddr = k_m1[AW-1:0];
        wdata = rdata;
        k_nxt = k_r + CW'(1);
      end
      S_MRG_WR: begin
        we = 1'b1;
        if (pred_merge) begin
          // fold into the free predecessor, then drop this entry
          waddr       = AW'(idx_r - CW'(1));
          wdata       = '{free: 1'b1,
                          size: SIZE_W'({2'b0, prev_sz_r} + {2'b0, cur_sz_r} + HDR27)};
          k_nxt       = idx_p1;
          sd_last_nxt = 1'b1;
        end else begin
          waddr         = idx_r[AW-1:0];
          wdata         = '{free: 1'b1, size: cur_sz_r};
          out_nxt       = '{alloc_address: '0, success: 1'b1};
          out_valid_nxt = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    need_r      <= need_nxt;
    addr_r      <= addr_nxt;
    idx_r       <= idx_nxt;
    k_r         <= k_nxt;
    start_r     <= start_nxt;
    cur_sz_r    <= cur_sz_nxt;
    rest_r      <= rest_nxt;
    prev_sz_r   <= prev_sz_nxt;
    prev_free_r <= prev_free_nxt;
    sd_last_r   <= sd_last_nxt;
    out_r       <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_valid_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_DONE)
    else $error("result valid outside done state");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_INIT |-> (count_r != '0) && (count_r <= MAX_CNT))
    else $error("block count out of range");
  a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.success) |-> out_r.alloc_address == '0)
    else $error("failed request carries an address");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK |-> idx_r < count_r)
    else $error("table check beyond live entries");
`endif

endmodule
